[rtl/tpcq_pkg.sv]
package tpcq_pkg;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_PRESS   = 3'd1,
        PH_SAMPLE  = 3'd2,
        PH_RELEASE = 3'd3,
        PH_DONE    = 3'd4
    } phase_t;

    localparam int SAMPLES_PER_POINT_DEF = 8;
    localparam int RAW_BITS_DEF          = 12;

    // fixed field widths
    localparam int FIELD_W  = 12;
    localparam int IDX_W    = 4;
    localparam int CNT_W    = 5;
    localparam int CFG_IDX_W = 4;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 40;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SPREAD    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_RAW_LEVEL = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RAW_LEVEL = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_POINTS_IN_RUN = 4'd3;

    localparam logic [FIELD_W-1:0] MAX_SPREAD_RST    = 12'd140;
    localparam logic [FIELD_W-1:0] MIN_RAW_LEVEL_RST = 12'd80;
    localparam logic [FIELD_W-1:0] MAX_RAW_LEVEL_RST = 12'd4000;
    localparam logic [IDX_W-1:0]   POINTS_RST        = 4'd5;
    localparam logic [IDX_W-1:0]   MAX_POINTS        = 4'd8;

endpackage

[rtl/touch_point_capture_qualifier.sv]
// Touch calibration point capture qualifier. Each input transaction is a start command
// (s_tuser high) or one poll of the touch converter. After a start the block waits for a
// press, gathers SAMPLES_PER_POINT good samples while the pen stays down, checks per axis
// spread and truncated mean against the limits, and on release accepts a stable point or
// retakes an unstable one, until points_in_run points are done. Every input transaction
// gives exactly one result transaction carrying the state after it. One transaction is
// accepted per clock while the result register is free or being taken; a result is formed
// from the input register by one pass through the update logic (sample add, reciprocal
// multiply for the mean, limit compares) into the result register. The config port is
// always ready and must only be written while no transaction is in flight.
module touch_point_capture_qualifier #(
    parameter int SAMPLES_PER_POINT = tpcq_pkg::SAMPLES_PER_POINT_DEF,
    parameter int RAW_BITS          = tpcq_pkg::RAW_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // pen_down, reading_ok, raw_x[11:0], raw_y[11:0], zero fill
    input  logic [tpcq_pkg::S_TDATA_W-1:0]     s_tdata,
    // req_type
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // phase[2:0], point_number[3:0], samples_taken[4:0], point_stable, point_accepted,
    // avg_x[11:0], avg_y[11:0], sequence_done, zero fill
    output logic [tpcq_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tpcq_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tpcq_pkg::FIELD_W-1:0]       cfg_data
);
    import tpcq_pkg::*;

    localparam int TALLY_W = $clog2(SAMPLES_PER_POINT + 1);
    localparam int SUM_W   = RAW_BITS + $clog2(SAMPLES_PER_POINT);
    localparam int CMP_W   = (RAW_BITS > FIELD_W) ? RAW_BITS : FIELD_W;
    localparam int SHIFT   = SUM_W + $clog2(SAMPLES_PER_POINT);
    localparam int PROD_W  = SUM_W + SHIFT + 1;
    localparam longint unsigned RECIP_L =
        ((64'd1 << SHIFT) + SAMPLES_PER_POINT - 1) / SAMPLES_PER_POINT;
    localparam logic [SHIFT:0] RECIP = (SHIFT + 1)'(RECIP_L);
    localparam logic [TALLY_W-1:0] SPP_T = TALLY_W'(SAMPLES_PER_POINT);
    localparam logic [RAW_BITS-1:0] RAW_MASK = {RAW_BITS{1'b1}};

    // configuration
    logic [FIELD_W-1:0] max_spread_reg, min_raw_level_reg, max_raw_level_reg;
    logic [IDX_W-1:0]   points_in_run_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_spread_reg    <= MAX_SPREAD_RST;
            min_raw_level_reg <= MIN_RAW_LEVEL_RST;
            max_raw_level_reg <= MAX_RAW_LEVEL_RST;
            points_in_run_reg <= POINTS_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_MAX_SPREAD:    max_spread_reg    <= cfg_data;
                REG_MIN_RAW_LEVEL: min_raw_level_reg <= cfg_data;
                REG_MAX_RAW_LEVEL: max_raw_level_reg <= cfg_data;
                REG_POINTS_IN_RUN: points_in_run_reg <= cfg_data[IDX_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    logic               in_valid_reg;
    logic               in_start_reg, in_down_reg, in_ok_reg;
    logic [FIELD_W-1:0] in_x_reg, in_y_reg;
    logic               m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic               advance;

    assign advance  = in_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_start_reg <= s_tuser;
            in_down_reg  <= s_tdata[0];
            in_ok_reg    <= s_tdata[1];
            in_x_reg     <= s_tdata[13:2];
            in_y_reg     <= s_tdata[25:14];
        end
    end

    // capture state
    phase_t              phase_reg, phase_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [TALLY_W-1:0]  tally_reg, tally_next;
    logic [SUM_W-1:0]    sum_x_reg, sum_x_next, sum_y_reg, sum_y_next;
    logic [RAW_BITS-1:0] low_x_reg, low_x_next, high_x_reg, high_x_next;
    logic [RAW_BITS-1:0] low_y_reg, low_y_next, high_y_reg, high_y_next;
    logic                stable_reg, stable_next;
    logic [RAW_BITS-1:0] mean_x_reg, mean_x_next, mean_y_reg, mean_y_next;

    // sample add, applied only while the set has room
    logic [CMP_W-1:0]    x_wide, y_wide;
    logic [RAW_BITS-1:0] x_s, y_s;
    logic                room;
    logic [TALLY_W-1:0]  tally_chk;
    logic [SUM_W-1:0]    sum_x_chk, sum_y_chk;
    logic [RAW_BITS-1:0] low_x_chk, high_x_chk, low_y_chk, high_y_chk;

    assign x_wide = CMP_W'(in_x_reg);
    assign y_wide = CMP_W'(in_y_reg);
    assign x_s    = x_wide[RAW_BITS-1:0];
    assign y_s    = y_wide[RAW_BITS-1:0];
    assign room   = tally_reg < SPP_T;

    assign tally_chk  = room ? tally_reg + 1'b1 : tally_reg;
    assign sum_x_chk  = room ? sum_x_reg + SUM_W'(x_s) : sum_x_reg;
    assign sum_y_chk  = room ? sum_y_reg + SUM_W'(y_s) : sum_y_reg;
    assign low_x_chk  = (room && x_s < low_x_reg)  ? x_s : low_x_reg;
    assign high_x_chk = (room && x_s > high_x_reg) ? x_s : high_x_reg;
    assign low_y_chk  = (room && y_s < low_y_reg)  ? y_s : low_y_reg;
    assign high_y_chk = (room && y_s > high_y_reg) ? y_s : high_y_reg;

    // mean of a full set by exact reciprocal multiply
    logic [PROD_W-1:0]   prod_x, prod_y;
    logic [RAW_BITS-1:0] mean_x_calc, mean_y_calc;
    logic [CMP_W-1:0]    mean_x_w, mean_y_w, spread_x_w, spread_y_w;
    logic [CMP_W-1:0]    max_spread_w, min_level_w, max_level_w;
    logic                check_ok;

    assign prod_x      = PROD_W'(sum_x_chk) * PROD_W'(RECIP);
    assign prod_y      = PROD_W'(sum_y_chk) * PROD_W'(RECIP);
    assign mean_x_calc = prod_x[SHIFT +: RAW_BITS];
    assign mean_y_calc = prod_y[SHIFT +: RAW_BITS];
    assign mean_x_w    = CMP_W'(mean_x_calc);
    assign mean_y_w    = CMP_W'(mean_y_calc);
    assign spread_x_w  = CMP_W'(high_x_chk - low_x_chk);
    assign spread_y_w  = CMP_W'(high_y_chk - low_y_chk);
    assign max_spread_w = CMP_W'(max_spread_reg);
    assign min_level_w  = CMP_W'(min_raw_level_reg);
    assign max_level_w  = CMP_W'(max_raw_level_reg);

    assign check_ok = (spread_x_w <= max_spread_w) && (spread_y_w <= max_spread_w) &&
                      (mean_x_w >= min_level_w) && (mean_x_w <= max_level_w) &&
                      (mean_y_w >= min_level_w) && (mean_y_w <= max_level_w);

    logic [IDX_W-1:0] limit, idx_inc;
    assign limit   = (points_in_run_reg == '0) ? IDX_W'(1) :
                     (points_in_run_reg > MAX_POINTS) ? MAX_POINTS : points_in_run_reg;
    assign idx_inc = idx_reg + 1'b1;

    logic do_clear, do_first, do_add, do_check, accepted_c, done_c;

    // next state
    always_comb begin
        phase_next  = phase_reg;
        idx_next    = idx_reg;
        do_clear    = 1'b0;
        do_first    = 1'b0;
        do_add      = 1'b0;
        do_check    = 1'b0;
        accepted_c  = 1'b0;
        done_c      = 1'b0;
        if (in_start_reg) begin
            idx_next   = '0;
            phase_next = PH_PRESS;
            do_clear   = 1'b1;
        end else begin
            unique case (phase_reg)
                PH_PRESS: begin
                    if (in_down_reg && in_ok_reg) begin
                        do_first   = 1'b1;
                        phase_next = PH_SAMPLE;
                    end
                end
                PH_SAMPLE: begin
                    if (!in_down_reg) begin
                        phase_next = PH_PRESS;
                        do_clear   = 1'b1;
                    end else if (in_ok_reg) begin
                        do_add = 1'b1;
                        if (tally_chk >= SPP_T) begin
                            do_check   = 1'b1;
                            phase_next = PH_RELEASE;
                        end
                    end
                end
                PH_RELEASE: begin
                    if (!in_down_reg) begin
                        if (!stable_reg) begin
                            phase_next = PH_PRESS;
                            do_clear   = 1'b1;
                        end else begin
                            accepted_c = 1'b1;
                            idx_next   = idx_inc;
                            if (idx_inc >= limit) begin
                                phase_next = PH_DONE;
                                done_c     = 1'b1;
                            end else begin
                                phase_next = PH_PRESS;
                                do_clear   = 1'b1;
                            end
                        end
                    end
                end
                PH_IDLE, PH_DONE: ;
                default: ;
            endcase
        end
    end

    // set datapath
    always_comb begin
        tally_next  = tally_reg;
        sum_x_next  = sum_x_reg;
        sum_y_next  = sum_y_reg;
        low_x_next  = low_x_reg;
        high_x_next = high_x_reg;
        low_y_next  = low_y_reg;
        high_y_next = high_y_reg;
        stable_next = stable_reg;
        mean_x_next = mean_x_reg;
        mean_y_next = mean_y_reg;
        if (do_clear || do_first) begin
            tally_next  = '0;
            sum_x_next  = '0;
            sum_y_next  = '0;
            low_x_next  = RAW_MASK;
            high_x_next = '0;
            low_y_next  = RAW_MASK;
            high_y_next = '0;
            stable_next = 1'b0;
            mean_x_next = '0;
            mean_y_next = '0;
        end
        if (do_first) begin
            tally_next  = TALLY_W'(1);
            sum_x_next  = SUM_W'(x_s);
            sum_y_next  = SUM_W'(y_s);
            low_x_next  = x_s;
            high_x_next = x_s;
            low_y_next  = y_s;
            high_y_next = y_s;
        end
        if (do_add) begin
            tally_next  = tally_chk;
            sum_x_next  = sum_x_chk;
            sum_y_next  = sum_y_chk;
            low_x_next  = low_x_chk;
            high_x_next = high_x_chk;
            low_y_next  = low_y_chk;
            high_y_next = high_y_chk;
        end
        if (do_check) begin
            stable_next = check_ok;
            mean_x_next = mean_x_calc;
            mean_y_next = mean_y_calc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            idx_reg    <= '0;
            tally_reg  <= '0;
            sum_x_reg  <= '0;
            sum_y_reg  <= '0;
            low_x_reg  <= RAW_MASK;
            high_x_reg <= '0;
            low_y_reg  <= RAW_MASK;
            high_y_reg <= '0;
            stable_reg <= 1'b0;
            mean_x_reg <= '0;
            mean_y_reg <= '0;
        end else if (advance) begin
            phase_reg  <= phase_next;
            idx_reg    <= idx_next;
            tally_reg  <= tally_next;
            sum_x_reg  <= sum_x_next;
            sum_y_reg  <= sum_y_next;
            low_x_reg  <= low_x_next;
            high_x_reg <= high_x_next;
            low_y_reg  <= low_y_next;
            high_y_reg <= high_y_next;
            stable_reg <= stable_next;
            mean_x_reg <= mean_x_next;
            mean_y_reg <= mean_y_next;
        end
    end

    // result fields; an accepted point reports the means it was qualified with
    logic [M_TDATA_W-1:0] result;
    logic [CMP_W-1:0]     avg_x_w, avg_y_w;

    always_comb begin
        avg_x_w = accepted_c ? CMP_W'(mean_x_reg) : CMP_W'(mean_x_next);
        avg_y_w = accepted_c ? CMP_W'(mean_y_reg) : CMP_W'(mean_y_next);
        result          = '0;
        result[2:0]     = phase_next;
        result[6:3]     = idx_next;
        result[11:7]    = CNT_W'(tally_next);
        result[12]      = accepted_c | stable_next;
        result[13]      = accepted_c;
        result[25:14]   = avg_x_w[FIELD_W-1:0];
        result[37:26]   = avg_y_w[FIELD_W-1:0];
        result[38]      = done_c;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (advance) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_tdata_reg <= result;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    a_tally_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        tally_reg <= SPP_T)
        else $error("sample tally above set size");

    a_sample_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_SAMPLE || phase_reg == PH_RELEASE) |-> tally_reg != '0)
        else $error("sampling with an empty set");

    a_release_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_RELEASE) |-> tally_reg == SPP_T)
        else $error("waiting for release without a full set");

    a_range_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (tally_reg != '0) |-> (low_x_reg <= high_x_reg && low_y_reg <= high_y_reg))
        else $error("set minimum above maximum");

    a_done_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && done_c) |=> (phase_reg == PH_DONE && stable_reg))
        else $error("sequence done without a stable last point");
`endif

endmodule

[tb/touch_point_capture_qualifier_tb.sv]
`timescale 1ns / 100ps

module touch_point_capture_qualifier_tb;
    import tpcq_pkg::*;

    localparam int SAMPLES      = SAMPLES_PER_POINT_DEF;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE       = 8;     // well past the result latency
    localparam int RANDOM_ITEMS = 170;
    localparam int PRINT_LIMIT  = 40;

    // packed msb first, so the field order matches m_tdata[38:0]
    typedef struct packed {
        logic        done;
        logic [11:0] avg_y;
        logic [11:0] avg_x;
        logic        accepted;
        logic        stable;
        logic [4:0]  samples;
        logic [3:0]  point_number;
        logic [2:0]  phase;
    } capture_report_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [FIELD_W-1:0]   cfg_data;

    touch_point_capture_qualifier dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // register copy
    logic [11:0] lim_spread, lim_low, lim_high;
    logic [3:0]  lim_points;

    // capture state copy
    phase_t      cap_phase;
    logic [3:0]  cap_index;
    int unsigned tally, sum_x, sum_y;
    logic [11:0] lo_x, hi_x, lo_y, hi_y, mean_x, mean_y;
    logic        stable;

    capture_report_t pending_reports[$];

    int unsigned items_sent    = 0;
    int unsigned reports_seen  = 0;
    int unsigned points_taken  = 0;
    int unsigned runs_finished = 0;
    int unsigned error_count   = 0;
    int unsigned cycle_count   = 0;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          recv_hold;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic void clear_set();
        tally  = 0;
        stable = 1'b0;
        sum_x  = 0;
        sum_y  = 0;
        lo_x   = '1;
        hi_x   = '0;
        lo_y   = '1;
        hi_y   = '0;
        mean_x = '0;
        mean_y = '0;
    endfunction

    function automatic void add_sample(input logic [11:0] x, input logic [11:0] y);
        sum_x += x;
        sum_y += y;
        if (x < lo_x) lo_x = x;
        if (x > hi_x) hi_x = x;
        if (y < lo_y) lo_y = y;
        if (y > hi_y) hi_y = y;
        tally++;
    endfunction

    function automatic capture_report_t advance_capture(input bit req, input bit down,
                                                        input bit ok, input logic [11:0] x,
                                                        input logic [11:0] y);
        capture_report_t r;
        int              limit;
        bit              handed_on;
        logic [11:0]     shown_x, shown_y;
        limit = (lim_points == 0) ? 1 :
                ((lim_points > MAX_POINTS) ? int'(MAX_POINTS) : int'(lim_points));
        r = '0;
        handed_on = 1'b0;
        shown_x = '0;
        shown_y = '0;
        if (req) begin
            cap_index = '0;
            cap_phase = PH_PRESS;
            clear_set();
        end else begin
            case (cap_phase)
                PH_PRESS: begin
                    if (down && ok) begin
                        clear_set();
                        add_sample(x, y);
                        cap_phase = PH_SAMPLE;
                    end
                end
                PH_SAMPLE: begin
                    if (!down) begin
                        cap_phase = PH_PRESS;
                        clear_set();
                    end else if (ok) begin
                        if (tally < SAMPLES) add_sample(x, y);
                        if (tally >= SAMPLES) begin
                            mean_x = 12'(sum_x / tally);
                            mean_y = 12'(sum_y / tally);
                            stable = (hi_x - lo_x) <= lim_spread && (hi_y - lo_y) <= lim_spread
                                  && mean_x >= lim_low && mean_x <= lim_high
                                  && mean_y >= lim_low && mean_y <= lim_high;
                            cap_phase = PH_RELEASE;
                        end
                    end
                end
                PH_RELEASE: begin
                    if (!down) begin
                        if (!stable) begin
                            cap_phase = PH_PRESS;
                            clear_set();
                        end else begin
                            r.accepted = 1'b1;
                            cap_index = cap_index + 1'b1;
                            if (cap_index >= limit) begin
                                cap_phase = PH_DONE;
                                r.done = 1'b1;
                            end else begin
                                // the report still shows the point just taken
                                shown_x = mean_x;
                                shown_y = mean_y;
                                handed_on = 1'b1;
                                cap_phase = PH_PRESS;
                                clear_set();
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
        r.phase        = cap_phase;
        r.point_number = cap_index;
        r.samples      = 5'(tally);
        r.stable       = handed_on | stable;
        r.avg_x        = handed_on ? shown_x : mean_x;
        r.avg_y        = handed_on ? shown_y : mean_y;
        return r;
    endfunction

    function automatic logic [11:0] jittered(input int centre, input int jit);
        int v;
        v = centre + int'($urandom_range(2 * jit)) - jit;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return v[11:0];
    endfunction

    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= PRINT_LIMIT) $display("[%0t] error: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_error($sformatf("result %0d field %s got %0h expected %0h",
                                   reports_seen, name, got, want));
    endtask

    // result checker
    always @(posedge aclk) begin
        capture_report_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = capture_report_t'(m_tdata[38:0]);
            if (pending_reports.size() == 0) begin
                report_error($sformatf("result transaction %0h with nothing pending", m_tdata));
            end else begin
                want = pending_reports.pop_front();
                check_field("phase", 16'(got.phase), 16'(want.phase));
                check_field("point_number", 16'(got.point_number), 16'(want.point_number));
                check_field("samples_taken", 16'(got.samples), 16'(want.samples));
                check_field("point_stable", 16'(got.stable), 16'(want.stable));
                check_field("point_accepted", 16'(got.accepted), 16'(want.accepted));
                check_field("avg_x", 16'(got.avg_x), 16'(want.avg_x));
                check_field("avg_y", 16'(got.avg_y), 16'(want.avg_y));
                check_field("sequence_done", 16'(got.done), 16'(want.done));
                if (want.accepted) points_taken++;
                if (want.done) runs_finished++;
            end
            reports_seen++;
        end
    end

    // result side ready, with an optional long hold-off
    always @(negedge aclk) begin
        if (recv_hold > 0) begin
            m_tready <= 1'b0;
            recv_hold = recv_hold - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // entered and left just after a falling edge
    task automatic send_item(input bit req, input bit down, input bit ok,
                             input logic [11:0] x, input logic [11:0] y);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {6'b0, y, x, ok, down};
        do @(posedge aclk); while (!s_tready);
        pending_reports.push_back(advance_capture(req, down, ok, x, y));
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [11:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_MAX_SPREAD:    lim_spread = val;
            REG_MIN_RAW_LEVEL: lim_low    = val;
            REG_MAX_RAW_LEVEL: lim_high   = val;
            REG_POINTS_IN_RUN: lim_points = val[3:0];
            default: ;
        endcase
        @(negedge aclk);
    endtask

    task automatic apply_limits(input int spread, input int low, input int high,
                                input int points);
        wait_idle();
        write_reg(REG_MAX_SPREAD, 12'(spread));
        write_reg(REG_MIN_RAW_LEVEL, 12'(low));
        write_reg(REG_MAX_RAW_LEVEL, 12'(high));
        write_reg(REG_POINTS_IN_RUN, 12'(points & 15));
        cfg_valid <= 1'b0;
    endtask

    // press, gather a full set around (cx, cy), hold, then lift
    task automatic take_point(input int cx, input int cy, input int jit, input bit noisy,
                              input int hold);
        if (cap_phase == PH_IDLE || cap_phase == PH_DONE)
            send_item(1'b1, 1'($urandom), 1'($urandom), 12'($urandom), 12'($urandom));
        while (cap_phase != PH_RELEASE) begin
            if (noisy && $urandom_range(9) == 0)
                send_item(1'b0, 1'b1, 1'b0, 12'($urandom), 12'($urandom));
            else
                send_item(1'b0, 1'b1, 1'b1, jittered(cx, jit), jittered(cy, jit));
        end
        repeat (hold) send_item(1'b0, 1'b1, 1'($urandom), 12'($urandom), 12'($urandom));
        send_item(1'b0, 1'b0, 1'($urandom), 12'($urandom), 12'($urandom));
    endtask

    task automatic test_reset_defaults();
        send_item(1'b0, 1'b1, 1'b1, 12'hFFF, 12'h000);   // poll while idle
        send_item(1'b1, 1'b0, 1'b0, 12'h000, 12'h000);
        send_item(1'b0, 1'b0, 1'b1, 12'h123, 12'h456);   // no press yet
        send_item(1'b0, 1'b1, 1'b0, 12'h800, 12'h800);   // failed read
        send_item(1'b0, 1'b1, 1'b1, 12'hFFF, 12'hFFF);
        send_item(1'b0, 1'b1, 1'b0, 12'h000, 12'h000);   // failed read while sampling
        send_item(1'b0, 1'b0, 1'b1, 12'h555, 12'hAAA);   // lift before set is full
        take_point(2000, 1500, 30, 1'b0, 1);
        take_point(0, 4095, 0, 1'b0, 0);                 // mean out of range, retaken
    endtask

    task automatic test_register_extremes();
        apply_limits(0, 0, 4095, 1);
        take_point(1000, 3000, 0, 1'b0, 0);
        send_item(1'b0, 1'b0, 1'b1, 12'h001, 12'h002);   // polls while done
        send_item(1'b0, 1'b1, 1'b1, 12'hFFE, 12'h7FF);
        take_point(2048, 2048, 2048, 1'b0, 0);           // zero spread allowed: retaken
        send_item(1'b0, 1'b1, 1'b1, 12'h100, 12'h200);
        send_item(1'b0, 1'b1, 1'b1, 12'h101, 12'h201);
        send_item(1'b1, 1'b1, 1'b1, 12'h102, 12'h202);   // restart mid-set
        apply_limits(4095, 0, 4095, 0);                  // zero points acts as one
        take_point(2048, 2048, 2048, 1'b0, 0);
        apply_limits(140, 3000, 100, 15);                // crossed levels
        take_point(2000, 2000, 10, 1'b0, 0);
        apply_limits(140, 80, 4000, 15);                 // above eight acts as eight
        repeat (8) take_point($urandom_range(200, 3800), $urandom_range(200, 3800), 20, 1'b0, 0);
        apply_limits(140, 80, 4000, 8);
        send_item(1'b1, 1'b0, 1'b0, 12'h000, 12'h000);
        repeat (3) take_point($urandom_range(200, 3800), $urandom_range(200, 3800), 20, 1'b0, 0);
        apply_limits(140, 80, 4000, 2);                  // count lowered below the index
        take_point(3000, 1000, 20, 1'b0, 0);
    endtask

    task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct);
        int unsigned goal;
        int          pick;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        apply_limits($urandom_range(20, 400), $urandom_range(0, 300),
                     $urandom_range(3700, 4095), $urandom_range(1, 8));
        goal = items_sent + count;
        while (items_sent < goal) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                send_item($urandom_range(15) == 0, 1'($urandom), 1'($urandom),
                          12'($urandom), 12'($urandom));
            end else if (pick < 13) begin
                repeat ($urandom_range(1, 6))
                    send_item(1'b0, 1'b1, 1'b1, 12'($urandom), 12'($urandom));
                send_item(1'b0, 1'b0, 1'($urandom), 12'($urandom), 12'($urandom));
            end else if (pick < 16) begin
                send_item(1'b1, 1'($urandom), 1'($urandom), 12'($urandom), 12'($urandom));
            end else begin
                take_point($urandom_range(4095), $urandom_range(4095), $urandom_range(120),
                           1'b1, $urandom_range(2));
            end
        end
    endtask

    task automatic test_output_stall();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        wait_idle();
        recv_hold = 400;
        repeat (6) take_point($urandom_range(4095), $urandom_range(4095), $urandom_range(60),
                              1'b1, $urandom_range(2));
        wait_idle();
    endtask

    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tuser   <= 1'b0;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        lim_spread = MAX_SPREAD_RST;
        lim_low    = MIN_RAW_LEVEL_RST;
        lim_high   = MAX_RAW_LEVEL_RST;
        lim_points = POINTS_RST;
        cap_phase  = PH_IDLE;
        cap_index  = '0;
        clear_set();
        send_idle_pct = 14;
        recv_idle_pct = 54;
        recv_hold     = 0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_register_extremes();
        test_random_traffic(RANDOM_ITEMS, 14, 54);
        test_random_traffic(RANDOM_ITEMS, 54, 14);
        test_random_traffic(RANDOM_ITEMS, 0, 0);
        test_output_stall();
        wait_idle();

        $display("covered %0d transactions: reset defaults, register extremes, three idle mixes",
                 items_sent);
        $display("and a long output stall; %0d results, %0d points, %0d runs done, %0d errors",
                 reports_seen, points_taken, runs_finished, error_count);
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
